// File: hw/rtl/sha256_message_digest_core_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 core assertion macros
// Shared concurrent assertion forms for the SHA-256 message digest core.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sha256md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 core package
// Types, round constants, initial hash and round functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;
  typedef logic [5:0] fill_t;

  localparam int LengthWidthDefault = 64;
  localparam int DigestWords = 8;
  localparam int WordIdxW = $clog2(DigestWords);
  localparam int WordCntW = $clog2(DigestWords + 1);

  localparam fill_t FillLast = 6'd63;
  localparam fill_t PadLimit = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic put_data;
    logic put_pad;
    logic count_bits;
    logic put_len;
    logic start;
    logic round;
    logic add;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    fill_t fill;
    logic  round_last;
  } dp_status_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_s0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_s0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha256_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Byte-serial SHA-256: absorbs message bytes, pads, compresses and returns
// the eight digest words of each message.
// ----------------------------------------------------------------------------
// channel | valid / stall        | payload
// in      | in_valid / in_stall  | data_byte, byte_valid, last
// out     | out_valid / out_stall| digest_word, word_index, last_word
//
// A byte that does not complete a block is taken without leaving idle, so the
// following byte is accepted straight away. A byte that completes a block
// runs the 64 rounds of the single round unit plus start and chaining add.
// A last request adds a pad step and the length block, plus an extra block
// when the pad spills over (the pad step starts it), then hands off the
// digest once the output buffer is empty.
// Digest words leave from an output buffer, one per cycle while not stalled;
// input requests are taken again while the buffer drains.
// Reset (rst, synchronous) restores the initial hash and clears all counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_digest_core
  import sha256md_pkg::*;
#(
  parameter int LENGTH_WIDTH = LengthWidthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                byte_valid,
  input  wire logic                last,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      word_t               digest_word,
  output      logic [WordIdxW-1:0] word_index,
  output      logic                last_word
);

  dp_cmd_t    cmd;
  dp_status_t status;
  hash_t      chain;
  logic       out_empty;

  sha256md_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status),
    .out_empty  (out_empty),
    .cmd        (cmd)
  );

  sha256md_dp #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .status    (status),
    .chain     (chain)
  );

  sha256md_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (cmd.emit_load),
    .digest      (chain),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .empty       (out_empty)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sha256md_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 core controller
// Sequences byte intake, padding, length block, rounds and digest handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_message_digest_core_macros.svh"

module sha256md_ctrl
  import sha256md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       byte_valid,
  input  wire logic       last,
  input  wire dp_status_t status,
  input  wire logic       out_empty,
  output      dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_DATA = 3'b001,
    PH_PAD  = 3'b010,
    PH_LEN  = 3'b100
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_DATA;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      fin   <= fin_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    fin_next   = fin;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fin_next = last;
          if (byte_valid) begin
            cmd.put_data   = 1'b1;
            cmd.count_bits = 1'b1;
          end
          if (byte_valid && status.fill == FillLast) begin
            cmd.start  = 1'b1;
            phase_next = PH_DATA;
            state_next = S_ROUND;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.put_pad = 1'b1;
        if (status.fill inside {[PadLimit:FillLast]}) begin
          // no room for the length field: extra block
          cmd.start  = 1'b1;
          phase_next = PH_PAD;
          state_next = S_ROUND;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        cmd.start   = 1'b1;
        phase_next  = PH_LEN;
        state_next  = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        case (phase)
          PH_DATA: state_next = fin ? S_PAD : S_IDLE;
          PH_PAD:  state_next = S_LEN;
          PH_LEN:  state_next = S_EMIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (out_empty) begin
          cmd.emit_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SHA_ASSERT_NEXT(a_start_enters_rounds, clk, rst, cmd.start, state == S_ROUND, "start without rounds")
  `SHA_ASSERT_IMPLY(a_add_after_rounds, clk, rst, state == S_ADD, $past(state) == S_ROUND, "add without rounds")
  `SHA_ASSERT_IMPLY(a_load_when_empty, clk, rst, cmd.emit_load, out_empty, "digest load over pending words")

endmodule

`default_nettype wire

// File: hw/rtl/sha256md_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 core datapath
// Block window, schedule, round unit, chaining hash and length counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256md_dp
  import sha256md_pkg::*;
#(
  parameter int LENGTH_WIDTH = LengthWidthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    cmd,
  input  wire logic [7:0] data_byte,
  output      dp_status_t status,
  output      hash_t      chain
);

  word_t                   window [16];
  word_t                   wv     [8];
  fill_t                   fill;
  logic [LENGTH_WIDTH-1:0] bits;
  logic [5:0]              rnd;

  logic [7:0]  put_val;
  logic [63:0] len64;
  word_t       t1, t2, ch, maj, w_new;

  assign put_val = cmd.put_pad ? PadByte : data_byte;
  assign len64   = 64'(bits);

  always_comb begin
    ch    = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1    = wv[7] + big_s1(wv[4]) + ch + RoundK[rnd] + window[0];
    t2    = big_s0(wv[0]) + maj;
    w_new = small_s1(window[14]) + window[9] + small_s0(window[1]) + window[0];
  end

  assign status.fill       = fill;
  assign status.round_last = (rnd == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= InitHash;
      fill  <= '0;
      bits  <= '0;
      rnd   <= '0;
      for (int i = 0; i < 16; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cmd.put_data || cmd.put_pad) begin
        window[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= put_val;
        fill <= fill + 6'd1;
      end
      if (cmd.count_bits) begin
        bits <= bits + LENGTH_WIDTH'(8);
      end
      if (cmd.put_len) begin
        window[14] <= len64[63:32];
        window[15] <= len64[31:0];
      end
      if (cmd.start) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 6'd1;
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) begin
          window[i] <= window[i+1];
        end
        window[15] <= w_new;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
        for (int i = 0; i < 16; i++) begin
          window[i] <= '0;
        end
        fill <= '0;
      end
      if (cmd.emit_load) begin
        chain <= InitHash;
        bits  <= '0;
        fill  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sha256md_out.sv
// ----------------------------------------------------------------------------
// SHA-256 core digest output buffer
// Holds a finished digest and hands it out one word per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_message_digest_core_macros.svh"

module sha256md_out
  import sha256md_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire hash_t               digest,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      word_t               digest_word,
  output      logic [WordIdxW-1:0] word_index,
  output      logic                last_word,
  output      logic                empty
);

  hash_t               words;
  logic [WordCntW-1:0] cnt;
  logic [WordIdxW-1:0] idx;

  assign out_valid   = (cnt != '0);
  assign empty       = (cnt == '0);
  assign digest_word = words[0];
  assign word_index  = idx;
  assign last_word   = (idx == WordIdxW'(DigestWords - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= WordCntW'(DigestWords);
      idx <= '0;
    end else if (out_valid && !out_stall) begin
      cnt <= cnt - WordCntW'(1);
      idx <= idx + WordIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= digest;
    end else if (out_valid && !out_stall) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  `SHA_ASSERT_IMPLY(a_load_only_empty, clk, rst, load, cnt == '0, "digest overwritten")
  `SHA_ASSERT_IMPLY(a_last_is_final, clk, rst, out_valid && last_word, cnt == WordCntW'(1), "last word count mismatch")
  `SHA_ASSERT_NEXT(a_drained_after_last, clk, rst, out_valid && !out_stall && last_word, cnt == '0, "words left after last")

endmodule

`default_nettype wire
